FILE: sv/timed_valve_pump_sequencer_assert.svh
// Assertion macros used by the checker file of the valve and pump sequencer.
`ifndef TIMED_VALVE_PUMP_SEQUENCER_ASSERT_SVH
`define TIMED_VALVE_PUMP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define TVPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvps check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define TVPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvps check failed");

`endif

FILE: sv/tvps_pkg.sv
// Types and constants of the timed valve and pump sequencer.
package tvps_pkg;

    localparam int HOUR_W   = 6;
    localparam int MINUTE_W = 7;
    localparam int AVG_W    = 10;
    localparam int DUTY_W   = 8;
    localparam int TEMP_W   = 9;
    localparam int GAIN_W   = 8;
    localparam int PROD_W   = 17;
    localparam int RECIP_W  = 17;
    localparam int RECIP_SH = 20;
    localparam int QUOT_W   = 14;
    localparam int DUR_W    = 16;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;
    localparam int IDX_LSB  = 3;

    localparam logic [AVG_W-1:0]  TEMP_MIN = 10'd150;
    localparam logic [AVG_W-1:0]  TEMP_MAX = 10'd400;
    // floor(x/10) == (x * RECIP_10) >> 20 for every x below 262144
    localparam logic [RECIP_W-1:0] RECIP_10 = 17'd104858;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_HOLD = 8'd80;
    localparam logic [DUTY_W-1:0] DUTY_PUMP = 8'd180;
    localparam logic [DUTY_W-1:0] DUTY_OFF  = 8'd0;

    localparam logic [1:0] BOOST_LAST  = 2'd1;
    localparam logic [2:0] SETTLE_LAST = 3'd1;
    localparam logic [2:0] FINAL_LAST  = 3'd4;

    localparam logic [DUR_W-1:0] DUR_RESET = 16'd200;
    localparam logic [DUR_W-1:0] DUR_MIN   = 16'd1;

    localparam logic [DATA_W-1:0]   GAIN_RESET    = 64'h0000_0008_0909_090E;
    localparam logic [DATA_W-1:0]   OFFSET_RESET  = 64'h0000_005A_7373_73AA;
    localparam logic [HOUR_W-1:0]   MORNING_RESET = 6'h08;
    localparam logic [HOUR_W-1:0]   EVENING_RESET = 6'h20;
    localparam logic [MINUTE_W-1:0] MINUTE_RESET  = 7'h10;

    typedef enum logic [2:0] {
        REG_ENABLE  = 3'd0,
        REG_GAIN    = 3'd1,
        REG_OFFSET  = 3'd2,
        REG_MORNING = 3'd3,
        REG_EVENING = 3'd4,
        REG_MINUTE  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_BOOST,
        SQ_OUTPUT,
        SQ_STOP
    } seq_phase_t;

    typedef enum logic [3:0] {
        VP_CHECK,
        VP_OPEN,
        VP_REDUCE,
        VP_WAIT,
        VP_PUMP,
        VP_RUN,
        VP_STOPPUMP,
        VP_CLOSE,
        VP_FINAL
    } valve_phase_t;

    typedef struct packed {
        logic b_load;
        logic c_load;
    } pipe_ctl_t;

    typedef struct packed {
        logic morning;
        logic evening;
    } tick_hit_t;

endpackage

FILE: sv/tvps_ifaces.sv
// Tick input channel and drive result channel of the sequencer.
interface tvps_tick_if
    import tvps_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [HOUR_W-1:0]   hour_bcd;
    logic [MINUTE_W-1:0] minute_bcd;
    logic [AVG_W-1:0]    avg_temp;

    modport source (output valid, output hour_bcd, output minute_bcd, output avg_temp,
                    input ready);
    modport sink   (input valid, input hour_bcd, input minute_bcd, input avg_temp,
                    output ready);
endinterface

interface tvps_drive_if
    import tvps_pkg::*;
#(
    parameter int NUM_OUTPUTS = 5
) ();
    logic                   valid;
    logic                   ready;
    logic [NUM_OUTPUTS-1:0] valve_mask;
    logic [DUTY_W-1:0]      valve_duty;
    logic [DUTY_W-1:0]      pump_duty;
    logic                   boost_on;
    logic                   busy_res;

    modport source (output valid, output valve_mask, output valve_duty, output pump_duty,
                    output boost_on, output busy_res, input ready);
    modport sink   (input valid, input valve_mask, input valve_duty, input pump_duty,
                    input boost_on, input busy_res, output ready);
endinterface

FILE: sv/timed_valve_pump_sequencer.sv
// Top level of the timed valve and pump sequencer.
//
// Each tick beat carries the BCD time and the day average temperature; one drive beat comes
// back per tick, showing the valve mask, valve and pump duties, boost and busy after that
// tick's step. A new tick is taken every clock unless a stalled drive beat backs up the
// stages; each tick passes the input register, gain product stage, divide-by-ten stage, then
// the sequencer step that writes the drive register. The sequencer step is not pipelined:
// the next tick depends on the state it leaves; it sets the one-tick-per-clock rate. While a
// drive beat waits, ticks still fill the empty stages in front of it. Registers are written
// over APB at byte address 8*index; write them only while no tick is in flight.
module timed_valve_pump_sequencer
    import tvps_pkg::*;
#(
    parameter int NUM_OUTPUTS = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    tvps_tick_if.sink         tick,
    tvps_drive_if.source      drive,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int TW = 8 * NUM_OUTPUTS;

    logic [NUM_OUTPUTS-1:0]             enable_mask;
    logic [TW-1:0]                      gain_table;
    logic [TW-1:0]                      offset_table;
    logic [HOUR_W-1:0]                  morning_hour;
    logic [HOUR_W-1:0]                  evening_hour;
    logic [MINUTE_W-1:0]                trigger_minute;

    logic                               a_valid_reg, a_valid_next;
    logic                               b_valid_reg, b_valid_next;
    logic                               c_valid_reg, c_valid_next;
    logic                               out_valid_reg, out_valid_next;
    logic [HOUR_W-1:0]                  hour_reg;
    logic [MINUTE_W-1:0]                minute_reg;
    logic [AVG_W-1:0]                   avg_reg;

    logic                               a_load;
    logic                               step;
    pipe_ctl_t                          ctl;
    tick_hit_t                          hit;
    logic [NUM_OUTPUTS-1:0][QUOT_W-1:0] quot;

    tvps_cfg_regs #(
        .NUM_OUTPUTS(NUM_OUTPUTS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .enable_mask   (enable_mask),
        .gain_table    (gain_table),
        .offset_table  (offset_table),
        .morning_hour  (morning_hour),
        .evening_hour  (evening_hour),
        .trigger_minute(trigger_minute)
    );

    // Each stage loads when it is empty or its beat moves on this clock.
    always_comb
    begin
        step       = c_valid_reg && (!out_valid_reg || drive.ready);
        ctl.c_load = b_valid_reg && (!c_valid_reg || step);
        ctl.b_load = a_valid_reg && (!b_valid_reg || ctl.c_load);
        tick.ready = !a_valid_reg || ctl.b_load;
        a_load     = tick.valid && tick.ready;

        out_valid_next = step || (out_valid_reg && !drive.ready);
        c_valid_next   = ctl.c_load || (c_valid_reg && !step);
        b_valid_next   = ctl.b_load || (b_valid_reg && !ctl.c_load);
        a_valid_next   = a_load || (a_valid_reg && !ctl.b_load);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            hour_reg   <= tick.hour_bcd;
            minute_reg <= tick.minute_bcd;
            avg_reg    <= tick.avg_temp;
        end
    end

    tvps_tick_prep #(
        .NUM_OUTPUTS(NUM_OUTPUTS)
    ) u_prep (
        .clk           (clk),
        .ctl           (ctl),
        .hour_bcd      (hour_reg),
        .minute_bcd    (minute_reg),
        .avg_temp      (avg_reg),
        .morning_hour  (morning_hour),
        .evening_hour  (evening_hour),
        .trigger_minute(trigger_minute),
        .gain_table    (gain_table),
        .hit           (hit),
        .quot          (quot)
    );

    tvps_sequencer #(
        .NUM_OUTPUTS(NUM_OUTPUTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .hit         (hit),
        .quot        (quot),
        .enable_mask (enable_mask),
        .offset_table(offset_table),
        .valve_mask  (drive.valve_mask),
        .valve_duty  (drive.valve_duty),
        .pump_duty   (drive.pump_duty),
        .boost_on    (drive.boost_on),
        .busy        (drive.busy_res)
    );

    assign drive.valid = out_valid_reg;

endmodule

FILE: sv/tvps_cfg_regs.sv
// APB configuration registers of the sequencer.
module tvps_cfg_regs
    import tvps_pkg::*;
#(
    parameter int NUM_OUTPUTS = 5,
    localparam int TW = 8 * NUM_OUTPUTS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    output logic [NUM_OUTPUTS-1:0] enable_mask,
    output logic [TW-1:0]          gain_table,
    output logic [TW-1:0]          offset_table,
    output logic [HOUR_W-1:0]      morning_hour,
    output logic [HOUR_W-1:0]      evening_hour,
    output logic [MINUTE_W-1:0]    trigger_minute
);

    logic [NUM_OUTPUTS-1:0] enable_reg;
    logic [TW-1:0]          gain_reg;
    logic [TW-1:0]          offset_reg;
    logic [HOUR_W-1:0]      morning_reg;
    logic [HOUR_W-1:0]      evening_reg;
    logic [MINUTE_W-1:0]    minute_reg;
    logic                   wr_en;
    reg_idx_t               idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:IDX_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= '1;
            gain_reg    <= GAIN_RESET[TW-1:0];
            offset_reg  <= OFFSET_RESET[TW-1:0];
            morning_reg <= MORNING_RESET;
            evening_reg <= EVENING_RESET;
            minute_reg  <= MINUTE_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ENABLE:  enable_reg  <= pwdata[NUM_OUTPUTS-1:0];
                REG_GAIN:    gain_reg    <= pwdata[TW-1:0];
                REG_OFFSET:  offset_reg  <= pwdata[TW-1:0];
                REG_MORNING: morning_reg <= pwdata[HOUR_W-1:0];
                REG_EVENING: evening_reg <= pwdata[HOUR_W-1:0];
                REG_MINUTE:  minute_reg  <= pwdata[MINUTE_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ENABLE:  prdata = DATA_W'(enable_reg);
            REG_GAIN:    prdata = DATA_W'(gain_reg);
            REG_OFFSET:  prdata = DATA_W'(offset_reg);
            REG_MORNING: prdata = DATA_W'(morning_reg);
            REG_EVENING: prdata = DATA_W'(evening_reg);
            REG_MINUTE:  prdata = DATA_W'(minute_reg);
            default:     prdata = '0;
        endcase
    end

    assign enable_mask    = enable_reg;
    assign gain_table     = gain_reg;
    assign offset_table   = offset_reg;
    assign morning_hour   = morning_reg;
    assign evening_hour   = evening_reg;
    assign trigger_minute = minute_reg;

endmodule

FILE: sv/tvps_tick_prep.sv
// Two tick stages: clamp, time match and gain product, then divide by ten.
module tvps_tick_prep
    import tvps_pkg::*;
#(
    parameter int NUM_OUTPUTS = 5,
    localparam int TW = 8 * NUM_OUTPUTS
) (
    input  logic                                clk,
    input  pipe_ctl_t                           ctl,
    input  logic [HOUR_W-1:0]                   hour_bcd,
    input  logic [MINUTE_W-1:0]                 minute_bcd,
    input  logic [AVG_W-1:0]                    avg_temp,
    input  logic [HOUR_W-1:0]                   morning_hour,
    input  logic [HOUR_W-1:0]                   evening_hour,
    input  logic [MINUTE_W-1:0]                 trigger_minute,
    input  logic [TW-1:0]                       gain_table,
    output tick_hit_t                           hit,
    output logic [NUM_OUTPUTS-1:0][QUOT_W-1:0]  quot
);

    logic [TEMP_W-1:0]                          temp;
    tick_hit_t                                  hit_next;
    tick_hit_t                                  hit_b_reg;
    tick_hit_t                                  hit_c_reg;
    logic [NUM_OUTPUTS-1:0][PROD_W-1:0]         prod_next;
    logic [NUM_OUTPUTS-1:0][PROD_W-1:0]         prod_reg;
    logic [NUM_OUTPUTS-1:0][PROD_W+RECIP_W-1:0] recip_prod;
    logic [NUM_OUTPUTS-1:0][QUOT_W-1:0]         quot_next;
    logic [NUM_OUTPUTS-1:0][QUOT_W-1:0]         quot_reg;

    always_comb
    begin
        if (avg_temp > TEMP_MAX)
            temp = TEMP_MAX[TEMP_W-1:0];
        else if (avg_temp < TEMP_MIN)
            temp = TEMP_MIN[TEMP_W-1:0];
        else
            temp = avg_temp[TEMP_W-1:0];

        hit_next.morning = (hour_bcd == morning_hour) && (minute_bcd == trigger_minute);
        hit_next.evening = (hour_bcd == evening_hour) && (minute_bcd == trigger_minute);

        for (int i = 0; i < NUM_OUTPUTS; i++)
        begin
            prod_next[i] = PROD_W'(temp) * PROD_W'(gain_table[GAIN_W*i +: GAIN_W]);
        end
    end

    // Divide by ten: multiply by the reciprocal and keep the high bits.
    always_comb
    begin
        for (int i = 0; i < NUM_OUTPUTS; i++)
        begin
            recip_prod[i] = (PROD_W+RECIP_W)'(prod_reg[i])
                          * (PROD_W+RECIP_W)'(RECIP_10);
            quot_next[i]  = recip_prod[i][RECIP_SH +: QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.b_load)
        begin
            hit_b_reg <= hit_next;
            prod_reg  <= prod_next;
        end
        if (ctl.c_load)
        begin
            hit_c_reg <= hit_b_reg;
            quot_reg  <= quot_next;
        end
    end

    assign hit  = hit_c_reg;
    assign quot = quot_reg;

endmodule

FILE: sv/tvps_sequencer.sv
// Watering time check, duration store and the boost/valve/pump state machine.
module tvps_sequencer
    import tvps_pkg::*;
#(
    parameter int NUM_OUTPUTS = 5,
    localparam int TW = 8 * NUM_OUTPUTS,
    localparam int OW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  tick_hit_t                          hit,
    input  logic [NUM_OUTPUTS-1:0][QUOT_W-1:0] quot,
    input  logic [NUM_OUTPUTS-1:0]             enable_mask,
    input  logic [TW-1:0]                      offset_table,
    output logic [NUM_OUTPUTS-1:0]             valve_mask,
    output logic [DUTY_W-1:0]                  valve_duty,
    output logic [DUTY_W-1:0]                  pump_duty,
    output logic                               boost_on,
    output logic                               busy
);

    seq_phase_t                        seq_reg,    seq_next;
    valve_phase_t                      vph_reg,    vph_next;
    logic [OW-1:0]                     cur_reg,    cur_next;
    logic [DUR_W-1:0]                  cd_reg,     cd_next;
    logic [2:0]                        sc_reg,     sc_next;
    logic [1:0]                        bc_reg,     bc_next;
    logic                              armed_reg,  armed_next;
    logic                              mdone_reg,  mdone_next;
    logic                              edone_reg,  edone_next;
    logic [NUM_OUTPUTS-1:0][DUR_W-1:0] dur_reg,    dur_next;
    logic [NUM_OUTPUTS-1:0]            valves_reg, valves_next;
    logic [DUTY_W-1:0]                 vduty_reg,  vduty_next;
    logic [DUTY_W-1:0]                 pduty_reg,  pduty_next;
    logic                              boost_reg,  boost_next;

    logic [NUM_OUTPUTS-1:0][DUR_W-1:0] new_dur;
    logic [NUM_OUTPUTS-1:0][QUOT_W-1:0] diff;
    logic [NUM_OUTPUTS-1:0][DUR_W:0]   diff10;
    logic                              load;
    logic                              vdone;
    logic [NUM_OUTPUTS-1:0]            cur_bit;
    logic [DUR_W-1:0]                  dur_sel;

    // Fresh durations: (quotient - offset) * 10, floor at one, cap at full scale.
    always_comb
    begin
        for (int i = 0; i < NUM_OUTPUTS; i++)
        begin
            diff[i]   = quot[i] - QUOT_W'(offset_table[GAIN_W*i +: GAIN_W]);
            diff10[i] = {diff[i], 3'b000} + {2'b00, diff[i], 1'b0};
            if (quot[i] <= QUOT_W'(offset_table[GAIN_W*i +: GAIN_W]))
                new_dur[i] = DUR_MIN;
            else if (diff10[i][DUR_W])
                new_dur[i] = '1;
            else
                new_dur[i] = diff10[i][DUR_W-1:0];
        end
    end

    assign load    = (hit.morning && !mdone_reg) || (hit.evening && !edone_reg);
    assign cur_bit = NUM_OUTPUTS'(1) << cur_reg;
    // The time check of the same tick comes first, so a fresh load is seen here.
    assign dur_sel = load ? new_dur[cur_reg] : dur_reg[cur_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= SQ_IDLE;
            vph_reg    <= VP_CHECK;
            cur_reg    <= '0;
            cd_reg     <= '0;
            sc_reg     <= '0;
            bc_reg     <= '0;
            armed_reg  <= 1'b0;
            mdone_reg  <= 1'b0;
            edone_reg  <= 1'b0;
            dur_reg    <= {NUM_OUTPUTS{DUR_RESET}};
            valves_reg <= '0;
            vduty_reg  <= DUTY_OFF;
            pduty_reg  <= DUTY_OFF;
            boost_reg  <= 1'b0;
        end
        else
        begin
            seq_reg    <= seq_next;
            vph_reg    <= vph_next;
            cur_reg    <= cur_next;
            cd_reg     <= cd_next;
            sc_reg     <= sc_next;
            bc_reg     <= bc_next;
            armed_reg  <= armed_next;
            mdone_reg  <= mdone_next;
            edone_reg  <= edone_next;
            dur_reg    <= dur_next;
            valves_reg <= valves_next;
            vduty_reg  <= vduty_next;
            pduty_reg  <= pduty_next;
            boost_reg  <= boost_next;
        end
    end

    always_comb
    begin
        seq_next    = seq_reg;
        vph_next    = vph_reg;
        cur_next    = cur_reg;
        cd_next     = cd_reg;
        sc_next     = sc_reg;
        bc_next     = bc_reg;
        armed_next  = armed_reg;
        mdone_next  = mdone_reg;
        edone_next  = edone_reg;
        dur_next    = dur_reg;
        valves_next = valves_reg;
        vduty_next  = vduty_reg;
        pduty_next  = pduty_reg;
        boost_next  = boost_reg;
        vdone       = 1'b0;

        if (step)
        begin
            mdone_next = hit.morning;
            edone_next = hit.evening;
            if (load)
            begin
                dur_next   = new_dur;
                armed_next = 1'b1;
            end

            unique case (seq_reg)
                SQ_IDLE:
                begin
                    if (armed_reg || load)
                        seq_next = SQ_BOOST;
                end
                SQ_BOOST:
                begin
                    boost_next = 1'b1;
                    if (bc_reg == BOOST_LAST)
                    begin
                        bc_next  = '0;
                        cur_next = '0;
                        seq_next = SQ_OUTPUT;
                    end
                    else
                        bc_next = bc_reg + 2'd1;
                end
                SQ_OUTPUT:
                begin
                    unique case (vph_reg)
                        VP_CHECK:
                        begin
                            if (enable_mask[cur_reg])
                                vph_next = VP_OPEN;
                            else
                                vdone = 1'b1;
                        end
                        VP_OPEN:
                        begin
                            cd_next     = dur_sel;
                            valves_next = valves_reg | cur_bit;
                            vduty_next  = DUTY_FULL;
                            vph_next    = VP_REDUCE;
                        end
                        VP_REDUCE:
                        begin
                            vduty_next = DUTY_HOLD;
                            vph_next   = VP_WAIT;
                        end
                        VP_WAIT:
                        begin
                            if (sc_reg == SETTLE_LAST)
                            begin
                                sc_next  = '0;
                                vph_next = VP_PUMP;
                            end
                            else
                                sc_next = sc_reg + 3'd1;
                        end
                        VP_PUMP:
                        begin
                            pduty_next = DUTY_PUMP;
                            vph_next   = VP_RUN;
                        end
                        VP_RUN:
                        begin
                            if (cd_reg <= DUR_MIN)
                            begin
                                cd_next  = '0;
                                vph_next = VP_STOPPUMP;
                            end
                            else
                                cd_next = cd_reg - DUR_MIN;
                        end
                        VP_STOPPUMP:
                        begin
                            pduty_next = DUTY_OFF;
                            vph_next   = VP_CLOSE;
                        end
                        VP_CLOSE:
                        begin
                            valves_next = valves_reg & ~cur_bit;
                            vduty_next  = DUTY_OFF;
                            vph_next    = VP_FINAL;
                        end
                        VP_FINAL:
                        begin
                            if (sc_reg == FINAL_LAST)
                            begin
                                sc_next  = '0;
                                vph_next = VP_CHECK;
                                vdone    = 1'b1;
                            end
                            else
                                sc_next = sc_reg + 3'd1;
                        end
                        default:
                            vph_next = VP_CHECK;
                    endcase

                    // Advance to the next output, or wrap up after the last one.
                    if (vdone)
                    begin
                        if (cur_reg == OW'(NUM_OUTPUTS - 1))
                        begin
                            cur_next = '0;
                            seq_next = SQ_STOP;
                        end
                        else
                            cur_next = cur_reg + OW'(1);
                    end
                end
                SQ_STOP:
                begin
                    boost_next = 1'b0;
                    armed_next = 1'b0;
                    seq_next   = SQ_IDLE;
                end
                default:
                    seq_next = SQ_IDLE;
            endcase
        end
    end

    assign valve_mask = valves_reg;
    assign valve_duty = vduty_reg;
    assign pump_duty  = pduty_reg;
    assign boost_on   = boost_reg;
    assign busy       = (seq_reg != SQ_IDLE);

endmodule

FILE: sv/tvps_checker.sv
// Port-level checks of the sequencer and their binding to the top level.
`include "timed_valve_pump_sequencer_assert.svh"

module tvps_checker #(
    parameter int NUM_OUTPUTS = 5
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [NUM_OUTPUTS-1:0] valve_mask,
    input logic [7:0]             valve_duty,
    input logic [7:0]             pump_duty,
    input logic                   boost_on,
    input logic                   busy_res
);

    logic [NUM_OUTPUTS+17:0] fields;

    assign fields = {valve_mask, valve_duty, pump_duty, boost_on, busy_res};

    // A stalled drive beat holds all of its fields.
    `TVPS_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(fields))

    // Valves open one at a time, and only a driven valve has duty.
    `TVPS_ASSERT_NOW(a_one_valve, clk, rst_n, valve_duty != '0, $onehot(valve_mask))

    // The pump runs only through an open valve with boost on.
    `TVPS_ASSERT_NOW(a_pump_safe, clk, rst_n, pump_duty != '0, boost_on && busy_res && valve_mask != '0)

    // Boost is never left on outside a sequence.
    `TVPS_ASSERT_NOW(a_boost_busy, clk, rst_n, boost_on, busy_res)

endmodule

bind timed_valve_pump_sequencer tvps_checker #(
    .NUM_OUTPUTS(NUM_OUTPUTS)
) u_tvps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (drive.valid),
    .out_ready (drive.ready),
    .valve_mask(drive.valve_mask),
    .valve_duty(drive.valve_duty),
    .pump_duty (drive.pump_duty),
    .boost_on  (drive.boost_on),
    .busy_res  (drive.busy_res)
);
